// ===== hw/rtl/pop3_dfr_pkg.sv =====
// Types, codes and constants shared by the POP3 multi-line deframer.
`timescale 1ns / 1ps

package pop3_dfr_pkg;

    localparam int MAX_RESULTS = 7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [2:0] OK_LEN  = 3'd3;
    localparam logic [2:0] ERR_LEN = 3'd4;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_CMD   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EOD   = 2'd1,
        KIND_RAW   = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_MID   = 3'd1,
        ST_MIDCR = 3'd2,
        ST_DOT   = 3'd3,
        ST_DOTCR = 3'd4,
        ST_LOOK  = 3'd5
    } line_state_t;

    typedef struct packed {
        line_state_t line_state;
        logic [2:0]  la_count;
        logic        la_is_err;
        logic        data_ended;
    } dfr_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       line_end;
        logic       last;
    } result_t;

    localparam logic [2:0] REG_MODE = 3'd0;

    function automatic logic [7:0] pat_byte(input logic is_err, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (is_err)
        begin
            unique case (idx)
                2'd0: b = 8'h2D;
                2'd1: b = 8'h45;
                2'd2: b = 8'h52;
                2'd3: b = 8'h52;
            endcase
        end
        else
        begin
            unique case (idx)
                2'd0: b = 8'h2B;
                2'd1: b = 8'h4F;
                2'd2: b = 8'h4B;
                2'd3: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [7:0] b, input logic le);
        result_t r;
        r.kind     = k;
        r.data     = b;
        r.line_end = le;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/pop3_dfr_step.sv =====
// Decode of one input transfer into its list of results and the next deframer state.
`timescale 1ns / 1ps

module pop3_dfr_step
    import pop3_dfr_pkg::*;
(
    input  logic                         mode,
    input  dfr_state_t                   cur,
    input  logic [1:0]                   operation,
    input  logic [7:0]                   data_byte,
    output result_t [MAX_RESULTS-1:0]    res,
    output logic [2:0]                   res_count,
    output dfr_state_t                   nxt
);

    logic [2:0] n;
    logic       do_rel;
    logic       do_start;
    logic       do_mid;
    logic       do_close;
    logic [2:0] la_len;
    logic [7:0] b;
    logic [2:0] c;
    logic       e;

    assign b      = data_byte;
    assign c      = cur.la_count;
    assign e      = cur.la_is_err;
    assign la_len = e ? ERR_LEN : OK_LEN;

    always_comb
    begin
        res      = '0;
        n        = 3'd0;
        nxt      = cur;
        do_rel   = 1'b0;
        do_start = 1'b0;
        do_mid   = 1'b0;
        do_close = 1'b0;

        unique case (op_t'(operation))
            OP_CMD:
            begin
                nxt.data_ended = 1'b0;
            end
            OP_NONE:
            begin
            end
            OP_CLOSE:
            begin
                if (mode && !cur.data_ended)
                begin
                    unique case (cur.line_state)
                        ST_MIDCR:
                        begin
                            res[n] = mk_res(KIND_DATA, CH_CR, 1'b0);
                            n = n + 3'd1;
                        end
                        ST_DOT:
                        begin
                            res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
                            n = n + 3'd1;
                        end
                        ST_DOTCR:
                        begin
                            res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
                            n = n + 3'd1;
                            res[n] = mk_res(KIND_DATA, CH_CR, 1'b0);
                            n = n + 3'd1;
                        end
                        ST_LOOK:
                        begin
                            if (c == 3'd0)
                            begin
                                res[n] = mk_res(KIND_EOD, 8'h00, 1'b0);
                                n = n + 3'd1;
                                nxt.data_ended = 1'b1;
                            end
                            else
                            begin
                                do_rel = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                do_close       = 1'b1;
                nxt.line_state = ST_START;
                nxt.la_count   = 3'd0;
                nxt.la_is_err  = 1'b0;
            end
            OP_BYTE:
            begin
                if (!mode || cur.data_ended)
                begin
                    res[n] = mk_res(KIND_RAW, b, b == CH_LF);
                    n = n + 3'd1;
                    nxt.line_state = (b == CH_LF) ? ST_START : ST_MID;
                    nxt.la_count   = 3'd0;
                    nxt.la_is_err  = 1'b0;
                end
                else
                begin
                    unique case (cur.line_state)
                        ST_MID:
                        begin
                            do_mid = 1'b1;
                        end
                        ST_MIDCR:
                        begin
                            if (b == CH_LF)
                            begin
                                res[n] = mk_res(KIND_DATA, CH_LF, 1'b1);
                                n = n + 3'd1;
                                nxt.line_state = ST_START;
                            end
                            else
                            begin
                                res[n] = mk_res(KIND_DATA, CH_CR, 1'b0);
                                n = n + 3'd1;
                                do_mid = 1'b1;
                            end
                        end
                        ST_DOT:
                        begin
                            if (b == CH_CR)
                            begin
                                nxt.line_state = ST_DOTCR;
                            end
                            else if (b == CH_LF)
                            begin
                                nxt.la_count   = 3'd0;
                                nxt.la_is_err  = 1'b0;
                                nxt.line_state = ST_LOOK;
                            end
                            else if (b == CH_DOT)
                            begin
                                res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
                                n = n + 3'd1;
                                nxt.line_state = ST_MID;
                            end
                            else
                            begin
                                res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
                                n = n + 3'd1;
                                do_mid = 1'b1;
                            end
                        end
                        ST_DOTCR:
                        begin
                            if (b == CH_LF)
                            begin
                                res[n] = mk_res(KIND_EOD, 8'h00, 1'b0);
                                n = n + 3'd1;
                                nxt.data_ended = 1'b1;
                                nxt.line_state = ST_START;
                            end
                            else
                            begin
                                res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
                                n = n + 3'd1;
                                res[n] = mk_res(KIND_DATA, CH_CR, 1'b0);
                                n = n + 3'd1;
                                do_mid = 1'b1;
                            end
                        end
                        ST_LOOK:
                        begin
                            if (c == 3'd0)
                            begin
                                if (b == CH_PLUS || b == CH_MINUS)
                                begin
                                    nxt.la_is_err = (b == CH_MINUS);
                                    nxt.la_count  = 3'd1;
                                end
                                else
                                begin
                                    do_rel        = 1'b1;
                                    nxt.la_count  = 3'd0;
                                    nxt.la_is_err = 1'b0;
                                    do_start      = 1'b1;
                                end
                            end
                            else if (c < la_len && b == pat_byte(e, c[1:0]))
                            begin
                                nxt.la_count = c + 3'd1;
                            end
                            else if (c >= la_len && (b == CH_CR || b == CH_LF))
                            begin
                                res[n] = mk_res(KIND_EOD, 8'h00, 1'b0);
                                n = n + 3'd1;
                                for (int i = 0; i < 4; i++)
                                begin
                                    if (3'(i) < la_len)
                                    begin
                                        res[n] = mk_res(KIND_RAW, pat_byte(e, 2'(i)), 1'b0);
                                        n = n + 3'd1;
                                    end
                                end
                                res[n] = mk_res(KIND_RAW, b, b == CH_LF);
                                n = n + 3'd1;
                                nxt.data_ended = 1'b1;
                                nxt.la_count   = 3'd0;
                                nxt.la_is_err  = 1'b0;
                                nxt.line_state = (b == CH_LF) ? ST_START : ST_MID;
                            end
                            else
                            begin
                                do_rel        = 1'b1;
                                nxt.la_count  = 3'd0;
                                nxt.la_is_err = 1'b0;
                                do_mid        = 1'b1;
                            end
                        end
                        default:
                        begin
                            do_start = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        // Held dot and line feed, then the partial pattern, come out as data.
        if (do_rel)
        begin
            res[n] = mk_res(KIND_DATA, CH_DOT, 1'b0);
            n = n + 3'd1;
            res[n] = mk_res(KIND_DATA, CH_LF, 1'b1);
            n = n + 3'd1;
            for (int i = 0; i < 4; i++)
            begin
                if (3'(i) < c)
                begin
                    res[n] = mk_res(KIND_DATA, pat_byte(e, 2'(i)), 1'b0);
                    n = n + 3'd1;
                end
            end
        end

        if (do_start)
        begin
            if (b == CH_DOT)
            begin
                nxt.line_state = ST_DOT;
            end
            else
            begin
                do_mid = 1'b1;
            end
        end

        if (do_mid)
        begin
            if (b == CH_CR)
            begin
                nxt.line_state = ST_MIDCR;
            end
            else if (b == CH_LF)
            begin
                res[n] = mk_res(KIND_DATA, CH_LF, 1'b1);
                n = n + 3'd1;
                nxt.line_state = ST_START;
            end
            else
            begin
                res[n] = mk_res(KIND_DATA, b, 1'b0);
                n = n + 3'd1;
                nxt.line_state = ST_MID;
            end
        end

        if (do_close)
        begin
            res[n] = mk_res(KIND_CLOSE, 8'h00, 1'b0);
            n = n + 3'd1;
        end

        if (n != 3'd0)
        begin
            res[n - 3'd1].last = 1'b1;
        end
    end

    assign res_count = n;

endmodule

// ===== hw/rtl/pop3_multiline_deframer.sv =====
// Top level of the POP3 multi-line response deframer with its result buffer and register port.
`timescale 1ns / 1ps

// Input channel: in_valid/in_ready carry one transfer of operation and data_byte.
// Output channel: out_valid/out_ready carry one result of kind, out_byte, line_end
// and last; last marks the final result caused by an input transfer.
// The operating mode register sits at address 0 of the APB-style port; write it
// only while the block is idle. The block itself does not enforce this.
// Each accepted transfer is decoded in the cycle it is accepted; its results are
// loaded into a result buffer of up to seven entries and the first one is
// offered on the output in the next cycle, one result per cycle after that while
// the receiver takes them. A transfer that causes one result can follow in every
// cycle while the receiver is ready, so the block then sustains one byte per cycle.
// A transfer that causes several results holds the input while the buffer drains;
// a transfer that causes no result leaves the input ready for the next transfer.
// When the receiver stalls, the buffered results hold and the input is held
// until the last pending result is being taken.
// Reset empties the buffer, selects mode 0 (bytes pass through as raw results) and
// returns the decoder to the start of a line with no lookahead and no end of data.
module pop3_multiline_deframer
    import pop3_dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        line_end,
    output logic        last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                      mode_reg;
    dfr_state_t                state_reg;
    dfr_state_t                state_next;
    result_t [MAX_RESULTS-1:0] entries_reg;
    result_t [MAX_RESULTS-1:0] entries_next;
    logic [2:0]                count_reg;
    logic [2:0]                count_next;

    result_t [MAX_RESULTS-1:0] step_res;
    logic [2:0]                step_count;
    logic                      in_xfer;
    logic                      out_xfer;

    pop3_dfr_step u_step (
        .mode      (mode_reg),
        .cur       (state_reg),
        .operation (operation),
        .data_byte (data_byte),
        .res       (step_res),
        .res_count (step_count),
        .nxt       (state_next)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE[2]) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE[2])
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign out_valid = (count_reg != 3'd0);
    assign out_xfer  = out_valid && out_ready;
    assign in_ready  = (count_reg == 3'd0) || (count_reg == 3'd1 && out_ready);
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        if (in_xfer)
        begin
            entries_next = step_res;
            count_next   = step_count;
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entries_next[i] = entries_reg[i + 1];
            end
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            state_reg <= '{line_state: ST_START, la_count: 3'd0,
                           la_is_err: 1'b0, data_ended: 1'b0};
        end
        else
        begin
            count_reg <= count_next;
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    assign kind     = entries_reg[0].kind;
    assign out_byte = entries_reg[0].data;
    assign line_end = entries_reg[0].line_end;
    assign last     = entries_reg[0].last;

    // Only the final queued result of a transfer carries last.
    a_last_only_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > 3'd1 |-> !entries_reg[0].last)
        else $error("last set on a result that is not the final one");

    a_tail_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 3'd0 |-> entries_reg[count_reg - 3'd1].last)
        else $error("final queued result lacks last");

    a_lookahead_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.la_count != 3'd0 |-> state_reg.line_state == ST_LOOK)
        else $error("lookahead count set outside the lookahead state");

    a_look_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_state == ST_LOOK |-> !state_reg.data_ended)
        else $error("lookahead pending after end of data");

    a_lookahead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.la_count <= ERR_LEN)
        else $error("lookahead count beyond the longest pattern");

endmodule
